// ===== hw/rtl/ffc_pkg.sv =====
// Shared types and codes for the keypad calculator.
`default_nettype none
package ffc_pkg;

  // Key event kinds (travel on in_tuser)
  typedef enum logic [1:0] {
    CMD_DIGIT  = 2'd0,
    CMD_OPER   = 2'd1,
    CMD_EQUALS = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Entry phases as reported on the result
  typedef enum logic [2:0] {
    PH_EMPTY  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_OPER   = 3'd2,
    PH_SECOND = 3'd3,
    PH_EQUALS = 3'd4
  } phase_t;

  // Operation codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam int unsigned OUT_VAL_W = 32;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 104;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ITER = 2'd1,
    ST_FIN  = 2'd2,
    ST_SNAP = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic apply;   // apply the accepted key event
    logic step;    // one multiply/divide iteration
    logic finish;  // write the iterative result to the answer
    logic snap;    // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic long_op; // equals now needs the iterative unit
    logic last;    // final iteration in progress
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffc_ctrl.sv =====
// Sequencing state machine and result-beat handshake for the calculator.
`default_nettype none
module ffc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire ffc_pkg::cmd_t  in_cmd,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  wire ffc_pkg::dp_status_t status,
  output ffc_pkg::ctrl_cmd_t  cmd
);

  ffc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ffc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.apply = 1'b1;
          if (in_cmd == ffc_pkg::CMD_EQUALS && status.long_op) begin
            state_nxt = ffc_pkg::ST_ITER;
          end else begin
            state_nxt = ffc_pkg::ST_SNAP;
          end
        end
      end
      ffc_pkg::ST_ITER: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ffc_pkg::ST_FIN;
        end
      end
      ffc_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ffc_pkg::ST_SNAP;
      end
      ffc_pkg::ST_SNAP: begin
        // wait for the result slot to be free or draining
        if (!out_valid_r || out_tready) begin
          cmd.snap      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ffc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ffc_dp.sv =====
// Calculator datapath: entry registers, operand build, iterative multiply/divide.
`default_nettype none
module ffc_dp #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire ffc_pkg::ctrl_cmd_t             cmd,
  output ffc_pkg::dp_status_t                 status,
  input  wire ffc_pkg::cmd_t                  in_cmd,
  input  wire  [3:0]                          in_digit,
  input  wire  [2:0]                          in_operation,
  output logic [ffc_pkg::OUT_DATA_W-1:0]      out_data
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  ffc_pkg::phase_t phase_r;
  logic [DW-1:0]   first_r, second_r, answer_r;
  logic [2:0]      oper_r;
  logic            dz_r;

  // iterative unit
  logic [DW-1:0]   acc_r;    // product / remainder
  logic [DW-1:0]   opb_r;    // multiplicand / divisor
  logic [DW-1:0]   opq_r;    // multiplier / dividend, then quotient
  logic            neg_r;
  logic            is_div_r;
  logic [CW-1:0]   cnt_r;

  logic [DW-1:0]   first_x10, second_x10, digit_ext;
  logic [DW-1:0]   mag_a, mag_b;
  logic [DW:0]     rem_sh, rem_diff;
  logic [DW-1:0]   quot;
  logic            b_zero;

  logic [ffc_pkg::OUT_DATA_W-1:0] out_data_r;

  assign digit_ext  = DW'(in_digit);
  assign first_x10  = (first_r << 3) + (first_r << 1);
  assign second_x10 = (second_r << 3) + (second_r << 1);
  assign mag_a      = first_r[DW-1]  ? (~first_r + 1'b1)  : first_r;
  assign mag_b      = second_r[DW-1] ? (~second_r + 1'b1) : second_r;
  assign b_zero     = (second_r == '0);

  // restoring divide step
  assign rem_sh   = {acc_r, opq_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, opb_r};
  assign quot     = neg_r ? (~opq_r + 1'b1) : opq_r;

  assign status.long_op = (oper_r == ffc_pkg::OP_MUL) ||
                          (oper_r == ffc_pkg::OP_DIV && !b_zero);
  assign status.last    = (cnt_r == CW'(1));

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ffc_pkg::PH_EMPTY;
      first_r  <= '0;
      second_r <= '0;
      answer_r <= '0;
      oper_r   <= ffc_pkg::OP_NONE;
      dz_r     <= 1'b0;
    end else if (cmd.apply) begin
      case (in_cmd)
        ffc_pkg::CMD_DIGIT: begin
          case (phase_r)
            ffc_pkg::PH_EMPTY: begin
              first_r <= digit_ext;
              phase_r <= ffc_pkg::PH_FIRST;
            end
            ffc_pkg::PH_FIRST:  first_r <= first_x10 + digit_ext;
            ffc_pkg::PH_OPER: begin
              second_r <= digit_ext;
              phase_r  <= ffc_pkg::PH_SECOND;
            end
            ffc_pkg::PH_SECOND: second_r <= second_x10 + digit_ext;
            default: ;
          endcase
        end
        ffc_pkg::CMD_OPER: begin
          if (phase_r == ffc_pkg::PH_FIRST || phase_r == ffc_pkg::PH_EQUALS) begin
            if (phase_r == ffc_pkg::PH_EQUALS) begin
              first_r <= answer_r;  // chain from last answer
            end
            oper_r  <= (in_operation inside {[ffc_pkg::OP_ADD:ffc_pkg::OP_DIV]}) ?
                       in_operation : ffc_pkg::OP_NONE;
            phase_r <= ffc_pkg::PH_OPER;
          end
        end
        ffc_pkg::CMD_EQUALS: begin
          phase_r <= ffc_pkg::PH_EQUALS;
          dz_r    <= 1'b0;
          case (oper_r)
            ffc_pkg::OP_ADD: answer_r <= first_r + second_r;
            ffc_pkg::OP_SUB: answer_r <= first_r - second_r;
            ffc_pkg::OP_MUL: ;  // answer written at finish
            ffc_pkg::OP_DIV: begin
              if (b_zero) begin
                answer_r <= '0;
                dz_r     <= 1'b1;
              end
            end
            default: answer_r <= '0;
          endcase
        end
        default: phase_r <= ffc_pkg::PH_EMPTY;
      endcase
    end else if (cmd.finish) begin
      answer_r <= is_div_r ? quot : acc_r;
    end
  end

  // iterative multiply / divide, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      is_div_r <= (oper_r == ffc_pkg::OP_DIV);
      neg_r    <= first_r[DW-1] ^ second_r[DW-1];
      cnt_r    <= CW'(DW);
      acc_r    <= '0;
      if (oper_r == ffc_pkg::OP_DIV) begin
        opb_r <= mag_b;
        opq_r <= mag_a;
      end else begin
        opb_r <= first_r;
        opq_r <= second_r;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r - 1'b1;
      if (is_div_r) begin
        if (!rem_diff[DW]) begin
          acc_r <= rem_diff[DW-1:0];
          opq_r <= {opq_r[DW-2:0], 1'b1};
        end else begin
          acc_r <= rem_sh[DW-1:0];
          opq_r <= {opq_r[DW-2:0], 1'b0};
        end
      end else begin
        if (opq_r[0]) begin
          acc_r <= acc_r + opb_r;
        end
        opb_r <= opb_r << 1;
        opq_r <= opq_r >> 1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      out_data_r <= {1'b0,
                     dz_r,
                     ffc_pkg::OUT_VAL_W'(signed'(answer_r)),
                     ffc_pkg::OUT_VAL_W'(signed'(second_r)),
                     oper_r,
                     ffc_pkg::OUT_VAL_W'(signed'(first_r)),
                     phase_r};
    end
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/four_function_calculator_entry_core.sv =====
// Top level of the keypad-driven four-function integer calculator.
//
//  channel | ports            | beat contents (low bit first)
//  --------+------------------+------------------------------------------------
//  input   | in_t*  (slave)   | tuser[1:0] command; tdata digit[3:0], operation[6:4]
//  result  | out_t* (master)  | tdata phase, first_operand, pending_operation,
//          |                  |   second_operand, answer, divide_by_zero
//
// Every key beat yields exactly one result beat (a snapshot after the event).
// Digit, operator, clear and add/subtract/unset/zero-divisor equals go from IDLE
// straight to SNAP; multiply or nonzero-divisor divide equals first pass through
// ITER and FIN, the shift-add / restoring-divide unit retiring one bit per cycle.
// Reset (rst_n low, synchronous) returns to the empty phase with all values zero.
// A waiting result beat does not block the next key beat; only its snapshot waits.
`default_nettype none
module four_function_calculator_entry_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // key events
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [ffc_pkg::IN_DATA_W-1:0]     in_tdata,  // digit[3:0], operation[6:4], pad[7]
  input  wire  [1:0]                        in_tuser,  // command[1:0]
  // state snapshots
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [ffc_pkg::OUT_DATA_W-1:0]    out_tdata  // phase[2:0], first_operand[34:3],
                                                       // pending_operation[37:35],
                                                       // second_operand[69:38],
                                                       // answer[101:70],
                                                       // divide_by_zero[102], pad[103]
);

  ffc_pkg::ctrl_cmd_t  cmd;
  ffc_pkg::dp_status_t status;
  ffc_pkg::cmd_t       key_cmd;

  assign key_cmd = ffc_pkg::cmd_t'(in_tuser);

  // sequencing and output beat handshake
  ffc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (key_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // entry registers and arithmetic
  ffc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_cmd       (key_cmd),
    .in_digit     (in_tdata[3:0]),
    .in_operation (in_tdata[6:4]),
    .out_data     (out_tdata)
  );

endmodule
`default_nettype wire
